@@ hdl/slap_pkg.sv @@
package slap_pkg;

    // item opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    // mode codes as carried by new_mode
    localparam logic [2:0] MODE_CODE_OFF     = 3'd0;
    localparam logic [2:0] MODE_CODE_PAIRING = 3'd1;
    localparam logic [2:0] MODE_CODE_PAIRED  = 3'd2;
    localparam logic [2:0] MODE_CODE_PRESS   = 3'd3;
    localparam logic [2:0] MODE_CODE_ERROR   = 3'd4;

    // display mode, one-hot
    typedef enum logic [4:0] {
        MODE_OFF     = 5'b00001,
        MODE_PAIRING = 5'b00010,
        MODE_PAIRED  = 5'b00100,
        MODE_PRESS   = 5'b01000,
        MODE_ERROR   = 5'b10000
    } mode_t;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAIRING_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_PERIOD   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLASH_DURATION = 2'd2;

    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_DATA_W-1:0] PAIRING_PERIOD_RST = 16'd500;
    localparam logic [CFG_DATA_W-1:0] ERROR_PERIOD_RST   = 16'd250;
    localparam logic [CFG_DATA_W-1:0] FLASH_DURATION_RST = 16'd100;

    // APA102 frame: only the LED word varies, the rest is zero
    typedef struct packed {
        logic [7:0] bright;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } frame_t;

    // 0xE0 marker plus 5-bit global brightness
    function automatic logic [7:0] bright_byte(input logic [7:0] level);
        bright_byte = 8'hE0 | {3'b000, level[7:3]};
    endfunction

    localparam frame_t FRAME_DARK  = '{bright: 8'hE0, blue: 8'h00, green: 8'h00, red: 8'h00};
    localparam frame_t FRAME_BLUE  = '{bright: 8'hF0, blue: 8'hFF, green: 8'h00, red: 8'h00};
    localparam frame_t FRAME_GREEN = '{bright: 8'hF0, blue: 8'h00, green: 8'hFF, red: 8'h00};
    localparam frame_t FRAME_RED   = '{bright: 8'hF9, blue: 8'h00, green: 8'h00, red: 8'hFF};
    localparam frame_t FRAME_WHITE = '{bright: 8'hF9, blue: 8'hFF, green: 8'hFF, red: 8'hFF};

    // byte positions within a frame
    localparam int unsigned FRAME_LEN  = 12;
    localparam int unsigned BYTE_IDX_W = 4;
    localparam logic [BYTE_IDX_W-1:0] BYTE_BRIGHT = 4'd4;
    localparam logic [BYTE_IDX_W-1:0] BYTE_BLUE   = 4'd5;
    localparam logic [BYTE_IDX_W-1:0] BYTE_GREEN  = 4'd6;
    localparam logic [BYTE_IDX_W-1:0] BYTE_RED    = 4'd7;
    localparam logic [BYTE_IDX_W-1:0] BYTE_LAST   = 4'(FRAME_LEN - 1);

    localparam int unsigned FRAME_QUEUE_DEPTH = 4;

endpackage

@@ hdl/slap_front.sv @@
module slap_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [slap_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [slap_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic                                opcode,
    input  logic [2:0]                          new_mode,
    input  logic [31:0]                         time_ms,
    output logic                                q_push,
    output slap_pkg::frame_t                    q_data,
    input  logic                                q_full
);
    import slap_pkg::*;

    logic [CFG_DATA_W-1:0] pair_period_reg;
    logic [CFG_DATA_W-1:0] err_period_reg;
    logic [CFG_DATA_W-1:0] flash_reg;

    mode_t       mode_reg, mode_next;
    logic [31:0] toggle_time_reg, toggle_time_next;
    logic        blink_on_reg, blink_on_next;

    logic        accept;
    logic [31:0] elapsed;
    logic        set_ok;
    mode_t       set_mode;

    assign full    = q_full;
    assign accept  = push && !q_full;
    assign elapsed = time_ms - toggle_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_period_reg <= PAIRING_PERIOD_RST;
            err_period_reg  <= ERROR_PERIOD_RST;
            flash_reg       <= FLASH_DURATION_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PAIRING_PERIOD: pair_period_reg <= cfg_data;
                CFG_ERROR_PERIOD:   err_period_reg  <= cfg_data;
                CFG_FLASH_DURATION: flash_reg       <= cfg_data;
                default:            ;
            endcase
        end
    end

    // decode set-mode code; codes past error are dropped
    always_comb
    begin
        set_ok   = 1'b1;
        set_mode = MODE_OFF;
        case (new_mode)
            MODE_CODE_OFF:     set_mode = MODE_OFF;
            MODE_CODE_PAIRING: set_mode = MODE_PAIRING;
            MODE_CODE_PAIRED:  set_mode = MODE_PAIRED;
            MODE_CODE_PRESS:   set_mode = MODE_PRESS;
            MODE_CODE_ERROR:   set_mode = MODE_ERROR;
            default:           set_ok   = 1'b0;
        endcase
    end

    always_comb
    begin
        mode_next        = mode_reg;
        toggle_time_next = toggle_time_reg;
        blink_on_next    = blink_on_reg;
        q_push           = 1'b0;
        q_data           = FRAME_DARK;
        if (accept)
        begin
            if (opcode == OP_SET)
            begin
                if (set_ok)
                begin
                    mode_next        = set_mode;
                    toggle_time_next = time_ms;
                    blink_on_next    = 1'b0;
                end
            end
            else
            begin
                case (mode_reg)
                    MODE_OFF:
                    begin
                        q_push = 1'b1;
                    end
                    MODE_PAIRING:
                    begin
                        if (elapsed > {16'd0, pair_period_reg})
                        begin
                            blink_on_next    = !blink_on_reg;
                            toggle_time_next = time_ms;
                            q_push           = 1'b1;
                            q_data           = blink_on_reg ? FRAME_DARK : FRAME_BLUE;
                        end
                    end
                    MODE_PAIRED:
                    begin
                        q_push = 1'b1;
                        q_data = FRAME_GREEN;
                    end
                    MODE_PRESS:
                    begin
                        if (elapsed < {16'd0, flash_reg})
                        begin
                            q_push = 1'b1;
                            q_data = FRAME_WHITE;
                        end
                        else
                        begin
                            mode_next = MODE_PAIRED;
                        end
                    end
                    MODE_ERROR:
                    begin
                        if (elapsed > {16'd0, err_period_reg})
                        begin
                            blink_on_next    = !blink_on_reg;
                            toggle_time_next = time_ms;
                            q_push           = 1'b1;
                            q_data           = blink_on_reg ? FRAME_DARK : FRAME_RED;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_OFF;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_OFF;
            toggle_time_reg <= 32'd0;
            blink_on_reg    <= 1'b0;
        end
        else
        begin
            mode_reg        <= mode_next;
            toggle_time_reg <= toggle_time_next;
            blink_on_reg    <= blink_on_next;
        end
    end

endmodule

@@ hdl/slap_fifo.sv @@
module slap_fifo #(
    parameter int unsigned DEPTH = slap_pkg::FRAME_QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  slap_pkg::frame_t wr_data,
    output logic             full,
    input  logic             rd_en,
    output slap_pkg::frame_t rd_data,
    output logic             empty
);
    import slap_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    frame_t            slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_wr, do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hdl/slap_back.sv @@
module slap_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  slap_pkg::frame_t     q_data,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           frame_byte,
    output logic                 frame_last
);
    import slap_pkg::*;

    logic [BYTE_IDX_W-1:0] idx_reg, idx_next;
    logic                  valid_reg, valid_next;
    logic [7:0]            byte_reg, byte_next;
    logic                  last_reg, last_next;
    logic                  load;
    logic [7:0]            sel_byte;

    // output slot free or being drained this cycle
    assign load  = !q_empty && (!valid_reg || pop);
    assign q_pop = load && (idx_reg == BYTE_LAST);

    always_comb
    begin
        case (idx_reg)
            BYTE_BRIGHT: sel_byte = q_data.bright;
            BYTE_BLUE:   sel_byte = q_data.blue;
            BYTE_GREEN:  sel_byte = q_data.green;
            BYTE_RED:    sel_byte = q_data.red;
            default:     sel_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            byte_next  = sel_byte;
            last_next  = (idx_reg == BYTE_LAST);
            idx_next   = (idx_reg == BYTE_LAST) ? '0 : idx_reg + 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign empty      = !valid_reg;
    assign frame_byte = byte_reg;
    assign frame_last = last_reg;

endmodule

@@ hdl/status_led_pattern_apa102.sv @@
// A tick's frame goes through the frame queue, then out of the back's output register.
// A tick that emits a frame occupies the byte serializer for its 12 bytes, one byte
// per cycle while each byte is popped; set-mode items and silent ticks push no frame.
// The frame queue lets the front keep taking items while up to FRAME_DEPTH frames wait.
// Reset (rst_n, async, active low): mode off, dark blink phase, toggle time 0,
// periods 500/250 ms, flash 100 ms, frame queue and output emptied.
module status_led_pattern_apa102 #(
    parameter int unsigned FRAME_DEPTH = slap_pkg::FRAME_QUEUE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration writes
    input  logic                              cfg_we,
    input  logic [slap_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [slap_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input word
    input  logic                              push,
    output logic                              full,
    input  logic                              opcode,
    input  logic [2:0]                        new_mode,
    input  logic [31:0]                       time_ms,
    // result word
    output logic                              empty,
    input  logic                              pop,
    output logic [7:0]                        frame_byte,
    output logic                              frame_last
);
    import slap_pkg::*;

    // front -> queue
    logic   fq_push;
    frame_t fq_wdata;
    logic   fq_full;
    // queue -> back
    logic   fq_pop;
    frame_t fq_rdata;
    logic   fq_empty;

    // Front: mode/blink state machine. Each tick either updates state
    // silently or pushes one frame descriptor (brightness + BGR).
    slap_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .opcode    (opcode),
        .new_mode  (new_mode),
        .time_ms   (time_ms),
        .q_push    (fq_push),
        .q_data    (fq_wdata),
        .q_full    (fq_full)
    );

    // Descriptor queue decouples the state machine from the serializer.
    slap_fifo #(
        .DEPTH (FRAME_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_push),
        .wr_data (fq_wdata),
        .full    (fq_full),
        .rd_en   (fq_pop),
        .rd_data (fq_rdata),
        .empty   (fq_empty)
    );

    // Back: expands each descriptor into the 12-byte APA102 frame
    // (4 zero start bytes, LED word, 4 zero end bytes) into a output register.
    slap_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (fq_empty),
        .q_data     (fq_rdata),
        .q_pop      (fq_pop),
        .empty      (empty),
        .pop        (pop),
        .frame_byte (frame_byte),
        .frame_last (frame_last)
    );

endmodule

@@ test/frame_checker.sv @@
module frame_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [slap_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [slap_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             push,
    input  logic                             full,
    input  logic                             opcode,
    input  logic [2:0]                       new_mode,
    input  logic [31:0]                      time_ms,
    input  logic                             empty,
    input  logic                             pop,
    input  logic [7:0]                       frame_byte,
    input  logic                             frame_last,
    output int                               fail_count,
    output int                               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import slap_pkg::*;

    localparam int MAX_REPORTS = 10;

    localparam logic [7:0] LED_DARK   = 8'h00;
    localparam logic [7:0] LED_FULL   = 8'hFF;
    localparam logic [7:0] LEVEL_MID  = 8'd128;
    localparam logic [7:0] LEVEL_HIGH = 8'd200;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } led_word_t;

    led_word_t   expected_words[$];

    mode_t       shown_mode;
    logic [31:0] toggle_at;
    logic        lit;
    logic [15:0] pairing_ms;
    logic [15:0] error_ms;
    logic [15:0] flash_ms;
    int          mismatches;

    // one whole frame: start bytes, LED word, end bytes
    task automatic queue_frame(input logic [7:0] red, input logic [7:0] green,
                               input logic [7:0] blue, input logic [7:0] level);
        logic [7:0] bytes [FRAME_LEN];
        led_word_t  w;
        foreach (bytes[k])
            bytes[k] = 8'h00;
        bytes[BYTE_BRIGHT] = 8'hE0 | {3'b000, level[7:3]};
        bytes[BYTE_BLUE]   = blue;
        bytes[BYTE_GREEN]  = green;
        bytes[BYTE_RED]    = red;
        for (int k = 0; k < FRAME_LEN; k++)
        begin
            w.data = bytes[k];
            w.last = (k == FRAME_LEN - 1);
            expected_words.push_back(w);
        end
    endtask

    task automatic blink_step(input logic [31:0] now, input logic [15:0] period,
                              input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue, input logic [7:0] level);
        logic [31:0] elapsed;
        elapsed = now - toggle_at;
        if (elapsed > {16'h0000, period})
        begin
            lit       = ~lit;
            toggle_at = now;
            if (lit)
                queue_frame(red, green, blue, level);
            else
                queue_frame(LED_DARK, LED_DARK, LED_DARK, LED_DARK);
        end
    endtask

    task automatic predict_word(input logic op, input logic [2:0] code,
                                input logic [31:0] now);
        logic [31:0] elapsed;
        if (op == OP_SET)
        begin
            // unknown codes leave everything as it was
            if (code <= MODE_CODE_ERROR)
            begin
                case (code)
                    MODE_CODE_OFF:     shown_mode = MODE_OFF;
                    MODE_CODE_PAIRING: shown_mode = MODE_PAIRING;
                    MODE_CODE_PAIRED:  shown_mode = MODE_PAIRED;
                    MODE_CODE_PRESS:   shown_mode = MODE_PRESS;
                    default:           shown_mode = MODE_ERROR;
                endcase
                toggle_at = now;
                lit       = 1'b0;
            end
        end
        else
        begin
            case (shown_mode)
                MODE_OFF:
                    queue_frame(LED_DARK, LED_DARK, LED_DARK, LED_DARK);
                MODE_PAIRING:
                    blink_step(now, pairing_ms, LED_DARK, LED_DARK, LED_FULL, LEVEL_MID);
                MODE_PAIRED:
                    queue_frame(LED_DARK, LED_FULL, LED_DARK, LEVEL_MID);
                MODE_PRESS:
                begin
                    elapsed = now - toggle_at;
                    if (elapsed < {16'h0000, flash_ms})
                        queue_frame(LED_FULL, LED_FULL, LED_FULL, LEVEL_HIGH);
                    else
                        shown_mode = MODE_PAIRED;  // silent fall-back
                end
                MODE_ERROR:
                    blink_step(now, error_ms, LED_FULL, LED_DARK, LED_DARK, LEVEL_HIGH);
                default:
                    ;
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        led_word_t want;
        if (!rst_n)
        begin
            shown_mode = MODE_OFF;
            toggle_at  = 32'h0000_0000;
            lit        = 1'b0;
            pairing_ms = PAIRING_PERIOD_RST;
            error_ms   = ERROR_PERIOD_RST;
            flash_ms   = FLASH_DURATION_RST;
            mismatches = 0;
            expected_words.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PAIRING_PERIOD: pairing_ms = cfg_data;
                    CFG_ERROR_PERIOD:   error_ms   = cfg_data;
                    CFG_FLASH_DURATION: flash_ms   = cfg_data;
                    default:            ;
                endcase
            end

            // compare before predicting: a word taken now cannot come from an item taken now
            if (pop && !empty)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected word: byte %02h last %0b",
                                 $realtime, frame_byte, frame_last);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (frame_byte !== want.data || frame_last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"%0t: mismatch: expected byte %02h last %0b, ",
                                      "got byte %02h last %0b"},
                                     $realtime, want.data, want.last,
                                     frame_byte, frame_last);
                    end
                end
            end

            if (push && !full)
                predict_word(opcode, new_mode, time_ms);

            fail_count <= mismatches;
            pending    <= expected_words.size();
        end
    end

endmodule

@@ test/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import slap_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 11;
    localparam int IDLE_PCT      = 36;
    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 16;    // covers a silent item still at the front
    localparam int CYCLE_LIMIT   = 400000;

    // index outside the register list, writes must be ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    // mode codes with no meaning, a set with one of these is ignored
    localparam logic [2:0] MODE_CODE_BAD_LO  = 3'd5;
    localparam logic [2:0] MODE_CODE_BAD_MID = 3'd6;
    localparam logic [2:0] MODE_CODE_BAD_HI  = 3'd7;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   push;
    logic                   full;
    logic                   opcode;
    logic [2:0]             new_mode;
    logic [31:0]            time_ms;
    logic                   empty;
    logic                   pop;
    logic [7:0]             frame_byte;
    logic                   frame_last;

    int                     checker_fails;
    int                     words_pending;

    // stimulus control shared with the receiver process
    int                     idle_pct;
    int                     hold_reqs;
    int                     hold_served;
    int                     cycle_count;

    // what the sender knows of the current periods, only to shape the time steps
    logic [15:0]            pairing_gap;
    logic [15:0]            error_gap;
    logic [15:0]            flash_span;
    logic [31:0]            clock_ms;

    status_led_pattern_apa102 u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .opcode     (opcode),
        .new_mode   (new_mode),
        .time_ms    (time_ms),
        .empty      (empty),
        .pop        (pop),
        .frame_byte (frame_byte),
        .frame_last (frame_last)
    );

    frame_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .opcode     (opcode),
        .new_mode   (new_mode),
        .time_ms    (time_ms),
        .empty      (empty),
        .pop        (pop),
        .frame_byte (frame_byte),
        .frame_last (frame_last),
        .fail_count (checker_fails),
        .pending    (words_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // run guard
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Receiver: random pop, or a long hold-off when the sender asks for one.
    // The hold is counted here so the sender keeps pushing meanwhile.
    initial
    begin
        int hold_count;
        pop         = 1'b0;
        hold_served = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_reqs)
            begin
                hold_served++;
                pop <= 1'b0;
                hold_count = 0;
                while (hold_count < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    hold_count++;
                end
            end
            else
                pop <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Offer one input word and return at the edge that takes it. push stays
    // high on return, so back-to-back words need no gap.
    task automatic send_word(input logic op, input logic [2:0] code, input logic [31:0] t);
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push     <= 1'b1;
        opcode   <= op;
        new_mode <= code;
        time_ms  <= t;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Stop offering, wait for every expected word, then let a trailing
    // silent item clear the front.
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Registers only change while the block is idle.
    task automatic configure(input logic [15:0] p_ms, input logic [15:0] e_ms,
                             input logic [15:0] f_ms);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PAIRING_PERIOD;
        cfg_data  <= p_ms;
        @(posedge clk);
        cfg_index <= CFG_ERROR_PERIOD;
        cfg_data  <= e_ms;
        @(posedge clk);
        cfg_index <= CFG_FLASH_DURATION;
        cfg_data  <= f_ms;
        @(posedge clk);
        cfg_index <= CFG_UNUSED;
        cfg_data  <= 16'($urandom);
        @(posedge clk);
        cfg_we      <= 1'b0;
        pairing_gap  = p_ms;
        error_gap    = e_ms;
        flash_span   = f_ms;
    endtask

    // Mostly a mode set followed by a run of ticks stepped around the mode's
    // period, so blinks, boundaries and fall-backs all get hit; the rest is noise.
    task automatic random_traffic(input int count);
        int          done;
        int          ticks;
        int          span;
        int          pick;
        logic        op;
        logic [2:0]  code;
        logic [31:0] step;
        done     = 0;
        clock_ms = $urandom;
        while (done < count)
        begin
            if ($urandom_range(99) < 85)
            begin
                code = 3'($urandom_range(MODE_CODE_ERROR));
                case (code)
                    MODE_CODE_PAIRING: span = int'(pairing_gap);
                    MODE_CODE_ERROR:   span = int'(error_gap);
                    MODE_CODE_PRESS:   span = int'(flash_span);
                    default:           span = 32;
                endcase
                send_word(OP_SET, code, clock_ms);
                done++;
                ticks = $urandom_range(1, 8);
                repeat (ticks)
                begin
                    pick = $urandom_range(99);
                    if (pick < 10)
                        step = 32'd0;
                    else if (pick < 80)
                        step = $urandom_range(2 * span + 2);
                    else if (pick < 95)
                        step = span + $urandom_range(1);   // right on the boundary
                    else
                        step = $urandom;
                    clock_ms = clock_ms + step;
                    send_word(OP_TICK, 3'($urandom_range(7)), clock_ms);
                    done++;
                end
            end
            else
            begin
                op   = 1'($urandom_range(1));
                code = 3'($urandom_range(7));
                send_word(op, code, $urandom);
                if (!(op == OP_SET && code > MODE_CODE_ERROR))
                    done++;
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_PAIRING_PERIOD;
        cfg_data    = '0;
        push        = 1'b0;
        opcode      = OP_TICK;
        new_mode    = MODE_CODE_OFF;
        time_ms     = 32'h0;
        idle_pct    = IDLE_PCT;
        hold_reqs   = 0;
        pairing_gap = PAIRING_PERIOD_RST;
        error_gap   = ERROR_PERIOD_RST;
        flash_span  = FLASH_DURATION_RST;
        clock_ms    = 32'h0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, reset periods ---
        // off emits dark on every tick, new_mode ignored on a tick
        send_word(OP_TICK, MODE_CODE_OFF, 32'h0000_0000);
        send_word(OP_TICK, MODE_CODE_BAD_HI, 32'hFFFF_FFFF);
        // pairing: exactly the period is not enough, one more toggles
        send_word(OP_SET,  MODE_CODE_PAIRING, 32'd1000);
        send_word(OP_TICK, MODE_CODE_OFF, 32'd1500);
        send_word(OP_TICK, MODE_CODE_OFF, 32'd1501);
        send_word(OP_TICK, MODE_CODE_OFF, 32'd2002);
        send_word(OP_SET,  MODE_CODE_PAIRED, 32'd2100);
        send_word(OP_TICK, MODE_CODE_OFF, 32'd2200);
        // pedal press: white until the flash ends, then silent fall-back to paired
        send_word(OP_SET,  MODE_CODE_PRESS, 32'd3000);
        send_word(OP_TICK, MODE_CODE_OFF, 32'd3000);
        send_word(OP_TICK, MODE_CODE_OFF, 32'd3099);
        send_word(OP_TICK, MODE_CODE_OFF, 32'd3100);
        send_word(OP_TICK, MODE_CODE_OFF, 32'd3101);
        // error across the 32-bit wrap
        send_word(OP_SET,  MODE_CODE_ERROR, 32'hFFFF_FF06);
        send_word(OP_TICK, MODE_CODE_OFF, 32'h0000_0000);
        send_word(OP_TICK, MODE_CODE_OFF, 32'h0000_0001);
        // unknown mode codes change nothing
        send_word(OP_SET,  MODE_CODE_BAD_LO, 32'd7);
        send_word(OP_SET,  MODE_CODE_BAD_HI, 32'd7);
        send_word(OP_TICK, MODE_CODE_BAD_MID, 32'd2);
        send_word(OP_SET,  MODE_CODE_BAD_MID, 32'd9);
        send_word(OP_SET,  MODE_CODE_OFF, 32'd0);
        send_word(OP_TICK, MODE_CODE_PRESS, 32'd5);

        // --- directed, zero periods and zero flash ---
        configure(16'd0, 16'd0, 16'd0);
        send_word(OP_SET,  MODE_CODE_PAIRING, 32'd10);
        send_word(OP_TICK, MODE_CODE_OFF, 32'd10);
        send_word(OP_TICK, MODE_CODE_OFF, 32'd11);
        send_word(OP_TICK, MODE_CODE_OFF, 32'd11);
        send_word(OP_TICK, MODE_CODE_OFF, 32'd12);
        send_word(OP_SET,  MODE_CODE_PRESS, 32'd20);
        send_word(OP_TICK, MODE_CODE_OFF, 32'd20);
        send_word(OP_TICK, MODE_CODE_OFF, 32'd20);
        send_word(OP_SET,  MODE_CODE_ERROR, 32'd30);
        send_word(OP_TICK, MODE_CODE_OFF, 32'd31);

        // --- random, largest periods ---
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_traffic(90);

        // --- random, tiny periods, no idling at all, plus a backed-up receiver ---
        configure(16'($urandom_range(15)), 16'($urandom_range(15)), 16'($urandom_range(15)));
        idle_pct  <= 0;
        hold_reqs <= hold_reqs + 1;
        send_word(OP_SET, MODE_CODE_PAIRED, clock_ms);
        repeat (24)
        begin
            clock_ms = clock_ms + 1;
            send_word(OP_TICK, MODE_CODE_OFF, clock_ms);
        end
        random_traffic(100);

        // --- random, full-range periods ---
        configure(16'($urandom), 16'($urandom), 16'($urandom));
        idle_pct <= IDLE_PCT;
        random_traffic(100);

        // --- random, moderate periods ---
        configure(16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)),
                  16'($urandom_range(1, 300)));
        random_traffic(120);

        drain();
        if (checker_fails == 0 && words_pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/slap_pkg.sv
hdl/slap_front.sv
hdl/slap_fifo.sv
hdl/slap_back.sv
hdl/status_led_pattern_apa102.sv
test/frame_checker.sv
test/testbench.sv
